// File: hw/rtl/csb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the cross stencil blur unit.
// No dependencies; csb_front, csb_queue, csb_back and the top level import it.
package csb_pkg;

	// colour of one pixel, red in the upper byte
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} csb_rgb_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} csb_reg_idx_t;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 8'd128;
	localparam int MIN_SIZE = 3;

	// sum of five 8-bit samples
	localparam int SUM_W = 11;
	// floor(s / 5) == (s * 6554) >> 15 for every s below 16384
	localparam int BLUR_RECIP = 6554;
	localparam int BLUR_SHIFT = 15;
	localparam int PROD_W = 24;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QAW = 2;
	localparam int QCW = 3;

	localparam int POS_W = 7;

	// one resolved stencil: channel sums plus what the results need
	typedef struct packed {
		logic [SUM_W-1:0] sum_red;
		logic [SUM_W-1:0] sum_green;
		logic [SUM_W-1:0] sum_blue;
		csb_rgb_t center;
		csb_rgb_t pixel;
		logic [POS_W-1:0] mid_row;
		logic [POS_W-1:0] last_row;
		logic [POS_W-1:0] col;
		logic has_mid;
		logic border;
		logic has_last;
	} csb_entry_t;

	// divide a channel sum by five
	function automatic logic [7:0] csb_div5(input logic [SUM_W-1:0] s);
		logic [PROD_W-1:0] p;
		p = PROD_W'(s) * PROD_W'(BLUR_RECIP);
		return p[BLUR_SHIFT+7:BLUR_SHIFT];
	endfunction

endpackage

// File: hw/rtl/csb_pix_if.sv
`timescale 1ns / 1ps
// Pixel input channel: valid/ready handshake with colour and frame start.
// Depends on nothing.
interface csb_pix_if;
	logic valid;
	logic ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic frame_start;

	modport source(output valid, in_red, in_green, in_blue, frame_start, input ready);
	modport sink(input valid, in_red, in_green, in_blue, frame_start, output ready);
endinterface

// File: hw/rtl/csb_res_if.sv
`timescale 1ns / 1ps
// Result output channel: valid/ready handshake with colour and position.
// Depends on nothing.
interface csb_res_if;
	logic valid;
	logic ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [6:0] out_row;
	logic [6:0] out_col;
	logic run_last;

	modport source(output valid, out_red, out_green, out_blue, out_row, out_col, run_last,
		input ready);
	modport sink(input valid, out_red, out_green, out_blue, out_row, out_col, run_last,
		output ready);
endinterface

// File: hw/rtl/csb_front.sv
`timescale 1ns / 1ps
// Front of the blur unit: position counters, the two line stores, stencil sums.
// Depends on csb_pkg and csb_pix_if.
module csb_front
	import csb_pkg::*;
#(
	parameter int MAX_WIDTH,
	parameter int MAX_HEIGHT
) (
	input  logic clk,
	input  logic arst_n,
	csb_pix_if.sink pix,
	input  logic [CFG_DATA_W-1:0] frame_width,
	input  logic [CFG_DATA_W-1:0] frame_height,
	input  logic [QCW-1:0] q_count,
	output logic push,
	output csb_entry_t push_entry
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int SZW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
	localparam int SZH = (RW + 1 > CFG_DATA_W) ? RW + 1 : CFG_DATA_W;

	logic acc;
	logic [SZW-1:0] width_ext;
	logic [SZH-1:0] height_ext;
	logic [CW:0] w_eff;
	logic [RW:0] h_eff;

	logic [CW-1:0] col_q, col_base, col_pos, col_next, col_east;
	logic [RW-1:0] row_q, row_base, row_pos, row_next;
	logic [RW:0] row_step, row_inc;
	logic [CW:0] col_inc;
	logic at_row_end, has_mid, border, has_last;

	csb_rgb_t above_mem [MAX_WIDTH];
	csb_rgb_t two_mem [MAX_WIDTH];
	csb_rgb_t left_q;

	logic valid_s1;
	csb_rgb_t px_s1, center_raw_s1, east_raw_s1, north_raw_s1, byp_px_s1, byp_center_s1;
	logic fwd_center_s1, fwd_east_s1;
	logic [CW-1:0] col_s1;
	logic [POS_W-1:0] mid_row_s1, last_row_s1, col_out_s1;
	logic has_mid_s1, border_s1, has_last_s1;
	csb_rgb_t center_s1, north_s1, east_s1, px_in;

	assign acc = pix.valid && pix.ready;
	assign px_in = '{red: pix.in_red, green: pix.in_green, blue: pix.in_blue};

	// take a word only while the queue has room for it and the one in flight
	assign pix.ready = (q_count + QCW'(valid_s1)) < QCW'(QUEUE_DEPTH);

	// clamp the frame size to the supported range
	always_comb begin
		width_ext = SZW'(frame_width);
		height_ext = SZH'(frame_height);
		if (width_ext < SZW'(MIN_SIZE)) begin
			w_eff = (CW + 1)'(MIN_SIZE);
		end else if (width_ext > SZW'(MAX_WIDTH)) begin
			w_eff = (CW + 1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW + 1)'(width_ext);
		end
		if (height_ext < SZH'(MIN_SIZE)) begin
			h_eff = (RW + 1)'(MIN_SIZE);
		end else if (height_ext > SZH'(MAX_HEIGHT)) begin
			h_eff = (RW + 1)'(MAX_HEIGHT);
		end else begin
			h_eff = (RW + 1)'(height_ext);
		end
	end

	// place the incoming word in the frame and classify it
	always_comb begin
		col_base = pix.frame_start ? '0 : col_q;
		row_base = pix.frame_start ? '0 : row_q;
		if ({1'b0, col_base} >= w_eff) begin
			col_pos = '0;
			row_step = {1'b0, row_base} + (RW + 1)'(1);
		end else begin
			col_pos = col_base;
			row_step = {1'b0, row_base};
		end
		row_pos = (row_step >= h_eff) ? '0 : RW'(row_step);
		col_inc = {1'b0, col_pos} + (CW + 1)'(1);
		row_inc = {1'b0, row_pos} + (RW + 1)'(1);
		at_row_end = col_inc >= w_eff;
		col_east = CW'(col_inc);
		if (at_row_end) begin
			col_next = '0;
			row_next = (row_inc >= h_eff) ? '0 : RW'(row_inc);
		end else begin
			col_next = CW'(col_inc);
			row_next = row_pos;
		end
		has_mid = row_pos != '0;
		border = (row_pos == RW'(1)) || (col_pos == '0) || at_row_end;
		has_last = row_inc == h_eff;
	end

	// advance the position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

	// line stores: write the stage-1 word, read for the word just taken
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			above_mem[col_s1] <= px_s1;
			two_mem[col_s1] <= center_s1;
		end
		if (acc) begin
			center_raw_s1 <= above_mem[col_pos];
			east_raw_s1 <= above_mem[col_east];
			north_raw_s1 <= two_mem[col_pos];
		end
	end

	// stage 1 payload, with bypass of a store written on the same edge
	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1 <= px_in;
			col_s1 <= col_pos;
			mid_row_s1 <= POS_W'(row_pos - RW'(1));
			last_row_s1 <= POS_W'(row_pos);
			col_out_s1 <= POS_W'(col_pos);
			has_mid_s1 <= has_mid;
			border_s1 <= border;
			has_last_s1 <= has_last;
			fwd_center_s1 <= valid_s1 && (col_s1 == col_pos);
			fwd_east_s1 <= valid_s1 && (col_s1 == col_east);
			byp_px_s1 <= px_s1;
			byp_center_s1 <= center_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			left_q <= '0;
		end else begin
			valid_s1 <= acc;
			if (valid_s1) begin
				left_q <= center_s1;
			end
		end
	end

	// resolve neighbours and sum each channel
	always_comb begin
		center_s1 = fwd_center_s1 ? byp_px_s1 : center_raw_s1;
		north_s1 = fwd_center_s1 ? byp_center_s1 : north_raw_s1;
		east_s1 = fwd_east_s1 ? byp_px_s1 : east_raw_s1;

		push_entry.sum_red = SUM_W'(center_s1.red) + SUM_W'(north_s1.red)
			+ SUM_W'(px_s1.red) + SUM_W'(left_q.red) + SUM_W'(east_s1.red);
		push_entry.sum_green = SUM_W'(center_s1.green) + SUM_W'(north_s1.green)
			+ SUM_W'(px_s1.green) + SUM_W'(left_q.green) + SUM_W'(east_s1.green);
		push_entry.sum_blue = SUM_W'(center_s1.blue) + SUM_W'(north_s1.blue)
			+ SUM_W'(px_s1.blue) + SUM_W'(left_q.blue) + SUM_W'(east_s1.blue);
		push_entry.center = center_s1;
		push_entry.pixel = px_s1;
		push_entry.mid_row = mid_row_s1;
		push_entry.last_row = last_row_s1;
		push_entry.col = col_out_s1;
		push_entry.has_mid = has_mid_s1;
		push_entry.border = border_s1;
		push_entry.has_last = has_last_s1;
	end

	// drop words of the first row: they give no result
	assign push = valid_s1 && (has_mid_s1 || has_last_s1);

endmodule

// File: hw/rtl/csb_queue.sv
`timescale 1ns / 1ps
// Short queue of resolved stencils between the front and the back.
// Depends on csb_pkg.
module csb_queue
	import csb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  csb_entry_t push_entry,
	input  logic pop,
	output logic head_valid,
	output csb_entry_t head,
	output logic [QCW-1:0] count
);

	csb_entry_t slot_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QCW-1:0] count_q;

	assign head_valid = count_q != '0;
	assign head = slot_q[rd_q];
	assign count = count_q;

	// hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			count_q <= count_q + QCW'(push) - QCW'(pop);
		end
	end

endmodule

// File: hw/rtl/csb_back.sv
`timescale 1ns / 1ps
// Back of the blur unit: divide by five, pick pass-through, sequence results.
// Depends on csb_pkg and csb_res_if.
module csb_back
	import csb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  csb_entry_t head,
	output logic pop,
	csb_res_if.source res
);

	logic phase_q;
	logic out_valid_q;
	csb_rgb_t out_px_q;
	logic [POS_W-1:0] out_row_q, out_col_q;
	logic out_last_q;

	logic load, mid_sel, final_res;
	csb_rgb_t blur_px, next_px;
	logic [POS_W-1:0] next_row;
	logic next_last;

	// pick the result to load next
	always_comb begin
		load = head_valid && (!out_valid_q || res.ready);
		mid_sel = head.has_mid && !phase_q;
		final_res = !(mid_sel && head.has_last);
		pop = load && final_res;

		blur_px.red = csb_div5(head.sum_red);
		blur_px.green = csb_div5(head.sum_green);
		blur_px.blue = csb_div5(head.sum_blue);

		if (mid_sel) begin
			next_px = head.border ? head.center : blur_px;
			next_row = head.mid_row;
			next_last = !head.has_last;
		end else begin
			next_px = head.pixel;
			next_row = head.last_row;
			next_last = 1'b1;
		end
	end

	// track the second result of a last-row word, hold the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q <= !final_res;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_px_q <= next_px;
			out_row_q <= next_row;
			out_col_q <= head.col;
			out_last_q <= next_last;
		end
	end

	assign res.valid = out_valid_q;
	assign res.out_red = out_px_q.red;
	assign res.out_green = out_px_q.green;
	assign res.out_blue = out_px_q.blue;
	assign res.out_row = out_row_q;
	assign res.out_col = out_col_q;
	assign res.run_last = out_last_q;

endmodule

// File: hw/rtl/cross_stencil_blur_unit.sv
`timescale 1ns / 1ps
// Top level of the five-point cross blur: config registers, front, queue, back.
// Depends on csb_pkg, csb_pix_if, csb_res_if, csb_front, csb_queue, csb_back.
//
//  port       dir   handshake          payload
//  pix        in    valid / ready      in_red, in_green, in_blue, frame_start
//  res        out   valid / ready      out_red, out_green, out_blue, out_row,
//                                      out_col, run_last
//  cfg        in    cfg_we             cfg_index, cfg_data
//
// A word is taken every clock while the queue has room; a last-row word gives two
// results, one after the other, so across a last row the input slows once the
// four-entry queue fills. After a word is taken it passes the stage-1 registers
// (line store read), the queue (sums) and the output register (divide). Reset clears
// counters, the queue and output valid; the line stores are not cleared. Either side
// may stall.
module cross_stencil_blur_unit
	import csb_pkg::*;
#(
	parameter int MAX_WIDTH = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic clk,
	input  logic arst_n,
	csb_pix_if.sink pix,
	csb_res_if.source res,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CFG_DATA_W-1:0] frame_width_q, frame_height_q;
	logic push, pop, head_valid;
	csb_entry_t push_entry, head;
	logic [QCW-1:0] q_count;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= SIZE_RESET;
			frame_height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (csb_reg_idx_t'(cfg_index))
				REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	csb_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.frame_width(frame_width_q),
		.frame_height(frame_height_q),
		.q_count(q_count),
		.push(push),
		.push_entry(push_entry)
	);

	csb_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head_valid(head_valid),
		.head(head),
		.count(q_count)
	);

	csb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.res(res)
	);

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCW'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_count < QCW'(QUEUE_DEPTH)))
		else $error("push into a full queue");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && !res.run_last) |=>
		(res.valid && res.run_last && res.out_col == $past(res.out_col)))
		else $error("last-row pixel did not follow its row above");
`endif

endmodule
